// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/gsppm_pkg.sv
// Package for the gas sensor ppm converter: constants, curve tables, state types.
// No dependencies.
`timescale 1ns / 1ps
package gsppm_pkg;

  localparam int unsigned SAMPLES = 5;
  localparam int unsigned DIV_W   = 36;
  localparam int unsigned PADDR_W = 4;

  localparam logic [27:0] RES_MAX = 28'hFFFFFFF;
  localparam logic [19:0] PPM_MAX = 20'd1048575;
  localparam logic signed [31:0] X2_Q16 = 32'sd500724;

  localparam logic [27:0] RO_RESET  = 28'd2560000;
  localparam logic [15:0] LR_RESET  = 16'd1280;
  localparam logic [15:0] CAF_RESET = 16'd2516;

  typedef enum logic [1:0] {
    REG_MODE = 2'd0,
    REG_RO   = 2'd1,
    REG_LR   = 2'd2,
    REG_CAF  = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    GAS_LPG   = 2'd0,
    GAS_CO    = 2'd1,
    GAS_SMK   = 2'd2,
    GAS_RO    = 2'd3
  } gas_code_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RS_MUL, ST_DIV, ST_DIV_DONE, ST_ACC, ST_LG_NORM, ST_LG_SQ,
    ST_LG_DONE, ST_GAS, ST_KMUL, ST_EXP, ST_SRCH, ST_OUT
  } state_e;

  typedef enum logic [1:0] {DIV_RS, DIV_AVG, DIV_CAL} div_sel_e;
  typedef enum logic [1:0] {LG_AVG, LG_RO, LG_MID} lg_sel_e;

  function automatic logic signed [23:0] curve_y2(logic [1:0] g);
    logic signed [23:0] r;
    case (g)
      GAS_LPG:   r = 24'sd45718;
      GAS_CO:    r = 24'sd156749;
      GAS_SMK:   r = 24'sd115384;
      default:   r = 24'sd0;
    endcase
    return r;
  endfunction

  function automatic logic [17:0] curve_k(logic [1:0] g);
    logic [17:0] r;
    case (g)
      GAS_LPG:   r = 18'd139438;
      GAS_CO:    r = 18'd192753;
      GAS_SMK:   r = 18'd148945;
      default:   r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

// File: rtl/gas_sensor_ppm_converter_unit.sv
// Gas sensor ppm converter top level: sequencer around one shared multiplier,
// a restoring divider and a log2 unit. Depends on gsppm_pkg.
`timescale 1ns / 1ps
// A nonzero sample that does not close a group takes one multiply and 36
// steps of the restoring divider. The sample that closes a group adds a
// 36-step divide for the average; calibrate mode adds one more divide for Ro
// when CAF is nonzero. Measure mode takes two logarithms when Ro and the
// average are nonzero (each a normalizing shift plus 16 squarings on the
// shared 32x32 multiplier), then per gas a binary search of up to 20
// logarithms. The input is not ready until all results of a group are taken.
module gas_sensor_ppm_converter_unit import gsppm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [9:0]           adc_sample_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           gas_code_o,
  output logic [27:0]          reading_o,
  output logic                 last_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  state_e state_q, state_d;
  div_sel_e dsel_q, dsel_d;
  lg_sel_e lsel_q, lsel_d;

  logic        mode_q;
  logic [27:0] ro_q;
  logic [15:0] lr_q, caf_q;

  logic [33:0] sum_q, sum_d;
  logic [5:0]  cnt_q, cnt_d;

  logic [15:0]      rem_q, rem_d, dvs_q, dvs_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [5:0]       dcnt_q, dcnt_d;

  logic [27:0] avg_q, avg_d;
  logic [20:0] lga_q, lga_d, lgr_q, lgr_d, lgres_q, lgres_d;
  logic [31:0] lgm_q, lgm_d;
  logic [4:0]  lgn_q, lgn_d;
  logic [3:0]  lgi_q, lgi_d;

  logic [1:0]         g_q, g_d;
  logic [41:0]        prod_q, prod_d;
  logic               dneg_q, dneg_d;
  logic signed [31:0] e_q, e_d;
  logic [19:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;

  logic        outv_q, outv_d, last_q, last_d;
  logic [1:0]  code_q, code_d;
  logic [27:0] read_q, read_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [16:0] rem_sh, rem_sub;
  logic        div_ge;
  logic [32:0] sq_t;
  logic [33:0] sum_n;
  logic [5:0]  cnt_n;
  logic [27:0] quo_sat;
  logic signed [23:0] dk;
  logic [23:0] dabs;
  logic [25:0] sh;
  logic signed [31:0] e_n;
  logic [20:0] msum;

  assign mul_p = mul_a * mul_b;

  assign rem_sh  = {rem_q, quo_q[DIV_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign quo_sat = (|quo_q[DIV_W-1:28]) ? RES_MAX : quo_q[27:0];
  assign sq_t    = mul_p[63:31];
  assign sum_n   = sum_q + 34'(quo_q[27:0]);
  assign cnt_n   = cnt_q + 6'd1;
  assign msum    = {1'b0, lo_q} + {1'b0, hi_q} + 21'd1;

  assign dk   = $signed({3'b0, lga_q}) - $signed({3'b0, lgr_q}) - curve_y2(g_q);
  assign dabs = dk[23] ? 24'(-dk) : 24'(dk);
  assign sh   = dneg_q ? 26'((prod_q + 42'd65535) >> 16) : prod_q[41:16];
  assign e_n  = dneg_q ? (X2_Q16 + $signed({6'b0, sh})) : (X2_Q16 - $signed({6'b0, sh}));

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = outv_q;
  assign gas_code_o  = code_q;
  assign reading_o   = read_q;
  assign last_o      = last_q;
  assign pready      = 1'b1;

  always_comb begin
    prdata = '0;
    case (reg_idx_e'(paddr[3:2]))
      REG_MODE: prdata = {31'b0, mode_q};
      REG_RO:   prdata = {4'b0, ro_q};
      REG_LR:   prdata = {16'b0, lr_q};
      REG_CAF:  prdata = {16'b0, caf_q};
      default:  prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      ro_q   <= RO_RESET;
      lr_q   <= LR_RESET;
      caf_q  <= CAF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_e'(paddr[3:2]))
        REG_MODE: mode_q <= pwdata[0];
        REG_RO:   ro_q   <= pwdata[27:0];
        REG_LR:   lr_q   <= pwdata[15:0];
        REG_CAF:  caf_q  <= pwdata[15:0];
        default:  mode_q <= mode_q;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    dsel_d  = dsel_q;
    lsel_d  = lsel_q;
    sum_d   = sum_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    quo_d   = quo_q;
    dcnt_d  = dcnt_q;
    avg_d   = avg_q;
    lga_d   = lga_q;
    lgr_d   = lgr_q;
    lgres_d = lgres_q;
    lgm_d   = lgm_q;
    lgn_d   = lgn_q;
    lgi_d   = lgi_q;
    g_d     = g_q;
    prod_d  = prod_q;
    dneg_d  = dneg_q;
    e_d     = e_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    outv_d  = outv_q;
    code_d  = code_q;
    read_d  = read_q;
    last_d  = last_q;
    mul_a   = lgm_q;
    mul_b   = lgm_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (adc_sample_i == 10'd0) begin
            quo_d   = DIV_W'(RES_MAX);
            state_d = ST_ACC;
          end else begin
            dvs_d   = {6'b0, adc_sample_i};
            state_d = ST_RS_MUL;
          end
        end
      end
      ST_RS_MUL: begin
        mul_a   = 32'(lr_q);
        mul_b   = 32'(10'd1023 - dvs_q[9:0]);
        quo_d   = DIV_W'(mul_p[25:0]);
        rem_d   = '0;
        dcnt_d  = '0;
        dsel_d  = DIV_RS;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = div_ge ? rem_sub[15:0] : rem_sh[15:0];
        quo_d = {quo_q[DIV_W-2:0], div_ge};
        if (dcnt_q == 6'(DIV_W - 1)) begin
          state_d = ST_DIV_DONE;
        end else begin
          dcnt_d = dcnt_q + 6'd1;
        end
      end
      ST_DIV_DONE: begin
        case (dsel_q)
          DIV_RS: state_d = ST_ACC;
          DIV_AVG: begin
            avg_d = quo_sat;
            if (mode_q) begin
              if (caf_q == 16'd0) begin
                outv_d  = 1'b1;
                code_d  = GAS_RO;
                read_d  = RES_MAX;
                last_d  = 1'b1;
                state_d = ST_OUT;
              end else begin
                quo_d   = {quo_sat, 8'b0};
                dvs_d   = caf_q;
                rem_d   = '0;
                dcnt_d  = '0;
                dsel_d  = DIV_CAL;
                state_d = ST_DIV;
              end
            end else if (ro_q == 28'd0 || quo_sat == 28'd0) begin
              g_d     = GAS_LPG;
              state_d = ST_GAS;
            end else begin
              lgm_d   = {quo_sat, 4'b0};
              lgn_d   = 5'd27;
              lsel_d  = LG_AVG;
              state_d = ST_LG_NORM;
            end
          end
          DIV_CAL: begin
            outv_d  = 1'b1;
            code_d  = GAS_RO;
            read_d  = quo_sat;
            last_d  = 1'b1;
            state_d = ST_OUT;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_ACC: begin
        if (cnt_n < 6'(SAMPLES)) begin
          sum_d   = sum_n;
          cnt_d   = cnt_n;
          state_d = ST_IDLE;
        end else begin
          sum_d   = '0;
          cnt_d   = '0;
          quo_d   = DIV_W'(sum_n);
          dvs_d   = 16'(SAMPLES);
          rem_d   = '0;
          dcnt_d  = '0;
          dsel_d  = DIV_AVG;
          state_d = ST_DIV;
        end
      end
      ST_LG_NORM: begin
        if (lgm_q[31]) begin
          lgres_d = {lgn_q, 16'b0};
          lgi_d   = 4'd15;
          state_d = ST_LG_SQ;
        end else begin
          lgm_d = {lgm_q[30:0], 1'b0};
          lgn_d = lgn_q - 5'd1;
        end
      end
      ST_LG_SQ: begin
        if (sq_t[32]) begin
          lgm_d   = sq_t[32:1];
          lgres_d = lgres_q | (21'd1 << lgi_q);
        end else begin
          lgm_d = sq_t[31:0];
        end
        if (lgi_q == 4'd0) begin
          state_d = ST_LG_DONE;
        end else begin
          lgi_d = lgi_q - 4'd1;
        end
      end
      ST_LG_DONE: begin
        case (lsel_q)
          LG_AVG: begin
            lga_d   = lgres_q;
            lgm_d   = {ro_q, 4'b0};
            lgn_d   = 5'd27;
            lsel_d  = LG_RO;
            state_d = ST_LG_NORM;
          end
          LG_RO: begin
            lgr_d   = lgres_q;
            g_d     = GAS_LPG;
            state_d = ST_GAS;
          end
          LG_MID: begin
            if ($signed({11'b0, lgres_q}) <= e_q) begin
              lo_d = mid_q;
            end else begin
              hi_d = mid_q - 20'd1;
            end
            state_d = ST_SRCH;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_GAS: begin
        code_d = g_q;
        last_d = (g_q == GAS_SMK);
        if (ro_q == 28'd0) begin
          outv_d  = 1'b1;
          read_d  = '0;
          state_d = ST_OUT;
        end else if (avg_q == 28'd0) begin
          outv_d  = 1'b1;
          read_d  = 28'(PPM_MAX);
          state_d = ST_OUT;
        end else begin
          state_d = ST_KMUL;
        end
      end
      ST_KMUL: begin
        mul_a   = 32'(dabs);
        mul_b   = 32'(curve_k(g_q));
        prod_d  = mul_p[41:0];
        dneg_d  = dk[23];
        state_d = ST_EXP;
      end
      ST_EXP: begin
        if (e_n[31]) begin
          outv_d  = 1'b1;
          read_d  = '0;
          state_d = ST_OUT;
        end else begin
          e_d     = e_n;
          lo_d    = 20'd1;
          hi_d    = PPM_MAX;
          state_d = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          mid_d   = msum[20:1];
          lgm_d   = {8'b0, msum[20:1], 4'b0};
          lgn_d   = 5'd27;
          lsel_d  = LG_MID;
          state_d = ST_LG_NORM;
        end else begin
          outv_d  = 1'b1;
          read_d  = 28'(lo_q);
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          outv_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            g_d     = g_q + 2'd1;
            state_d = ST_GAS;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sum_q   <= '0;
      cnt_q   <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsel_q  <= dsel_d;
    lsel_q  <= lsel_d;
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    quo_q   <= quo_d;
    dcnt_q  <= dcnt_d;
    avg_q   <= avg_d;
    lga_q   <= lga_d;
    lgr_q   <= lgr_d;
    lgres_q <= lgres_d;
    lgm_q   <= lgm_d;
    lgn_q   <= lgn_d;
    lgi_q   <= lgi_d;
    g_q     <= g_d;
    prod_q  <= prod_d;
    dneg_q  <= dneg_d;
    e_q     <= e_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    code_q  <= code_d;
    read_q  <= read_d;
    last_q  <= last_d;
  end

endmodule

// File: rtl/gsppm_checker.sv
// Port-level checker for the gas sensor ppm converter, bound to the top level.
// Depends on gsppm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gsppm_checker import gsppm_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [1:0]          gas_code_o,
  input logic [27:0]         reading_o,
  input logic                last_o
);

  `ASSERT_ALWAYS(a_busy_excl, clk_i, !(in_ready_o && out_valid_o), "ready while word pending")
  `ASSERT_CLK(a_busy_after_in, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready after accept")
  `ASSERT_CLK(a_ppm_range, clk_i, rst_ni, (out_valid_o && gas_code_o != GAS_RO) |-> (reading_o <= 28'(PPM_MAX)), "ppm above max")
  `ASSERT_CLK(a_last_code, clk_i, rst_ni, out_valid_o |-> (last_o == (gas_code_o == GAS_SMK || gas_code_o == GAS_RO)), "last flag mismatch")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(reading_o)), "stalled word changed")

endmodule

bind gas_sensor_ppm_converter_unit gsppm_checker u_gsppm_checker (.*);
